// ===== design/alid_pkg.sv =====
package alid_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_READ   = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_APPEND = 3'd4,
    CMD_INSERT = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SHIFT_DN,
    ST_SHIFT_UP,
    ST_INS_WR
  } state_t;

endpackage

// ===== design/array_list_insert_delete.sv =====
// Fixed-capacity ordered list of signed 32-bit values (CAPACITY entries).
//
// Input channel: drive in_command, in_position and in_value_in with start
// high; the item is taken at the rising edge where start is high and busy
// is low. Commands: clear, read, overwrite, delete (shift down), append,
// insert (shift up). Codes 6 and 7 change nothing and report done.
//
// Result channel: out_valid pulses for one cycle with out_status,
// out_read_value, out_count and out_empty_res. The receiver cannot stall;
// each item yields exactly one result.
//
// Clear, overwrite, append, insert at count, rejected and unused items end
// in the accepting cycle; a read waits for the registered memory read; a
// delete moves entries position+1..count-1 down, a shifting insert moves
// count-1..position up and then writes the value. busy drops in the result
// cycle, so the next item can be taken at its end. One entry moves per
// cycle; the worst case is an insert at the front with CAPACITY-1 entries.
//
// Reset (rst_n low, synchronous) empties the list and idles the sequencer.
// Entry contents are not cleared; only entries below the count are read.
module array_list_insert_delete import alid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_command,
  input  logic [CNT_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value_in,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [CNT_W-1:0]         out_count,
  output logic                     out_empty_res
);

  // entry memory, one write and one registered read per cycle
  logic [DATA_W-1:0] mem_r [CAPACITY];
  logic [DATA_W-1:0] rdata_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;

  // sequencer state and item context
  state_t            state_r,  state_nxt;
  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic [CNT_W-1:0]  ptr_r,    ptr_nxt;   // address read in the last cycle
  logic [CNT_W-1:0]  pos_r,    pos_nxt;
  logic [DATA_W-1:0] val_r,    val_nxt;

  // result register
  logic              out_valid_r,      out_valid_nxt;
  status_t           out_status_r,     out_status_nxt;
  logic [DATA_W-1:0] out_read_value_r, out_read_value_nxt;
  logic [CNT_W-1:0]  out_count_r,      out_count_nxt;
  logic              out_empty_res_r,  out_empty_res_nxt;

  // shared pointer arithmetic
  logic [CNT_W-1:0]  pos_inc;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  ptr_inc;
  logic [CNT_W-1:0]  ptr_dec;

  assign pos_inc = in_position + CNT_W'(1);
  assign cnt_dec = cnt_r - CNT_W'(1);
  assign ptr_inc = ptr_r + CNT_W'(1);
  assign ptr_dec = ptr_r - CNT_W'(1);

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    logic    done;
    status_t stat;

    done               = 1'b0;
    stat               = STAT_OK;
    state_nxt          = state_r;
    cnt_nxt            = cnt_r;
    ptr_nxt            = ptr_r;
    pos_nxt            = pos_r;
    val_nxt            = val_r;
    out_read_value_nxt = '0;
    mem_we             = 1'b0;
    mem_waddr          = '0;
    mem_wdata          = '0;
    mem_raddr          = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          pos_nxt = in_position;
          val_nxt = in_value_in;
          case (in_command)
            CMD_CLEAR: begin
              cnt_nxt = '0;
              done    = 1'b1;
            end
            CMD_READ: begin
              if (in_position < cnt_r) begin
                mem_raddr = in_position[IDX_W-1:0];
                state_nxt = ST_RD_WAIT;
              end else begin
                stat = STAT_RANGE;
                done = 1'b1;
              end
            end
            CMD_WRITE: begin
              if (in_position < cnt_r) begin
                mem_we    = 1'b1;
                mem_waddr = in_position[IDX_W-1:0];
                mem_wdata = in_value_in;
              end else begin
                stat = STAT_RANGE;
              end
              done = 1'b1;
            end
            CMD_DELETE: begin
              if (in_position >= cnt_r) begin
                stat = STAT_RANGE;
                done = 1'b1;
              end else if (pos_inc < cnt_r) begin
                // start the shift-down: read entry position+1
                mem_raddr = pos_inc[IDX_W-1:0];
                ptr_nxt   = pos_inc;
                state_nxt = ST_SHIFT_DN;
              end else begin
                cnt_nxt = cnt_dec;
                done    = 1'b1;
              end
            end
            CMD_APPEND: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                stat = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_r[IDX_W-1:0];
                mem_wdata = in_value_in;
                cnt_nxt   = cnt_r + CNT_W'(1);
              end
              done = 1'b1;
            end
            CMD_INSERT: begin
              if (in_position > cnt_r) begin
                stat = STAT_RANGE;
                done = 1'b1;
              end else if (cnt_r == CNT_W'(CAPACITY)) begin
                stat = STAT_FULL;
                done = 1'b1;
              end else if (in_position == cnt_r) begin
                mem_we    = 1'b1;
                mem_waddr = in_position[IDX_W-1:0];
                mem_wdata = in_value_in;
                cnt_nxt   = cnt_r + CNT_W'(1);
                done      = 1'b1;
              end else begin
                // shift-up runs from the last entry toward position
                mem_raddr = cnt_dec[IDX_W-1:0];
                ptr_nxt   = cnt_dec;
                state_nxt = ST_SHIFT_UP;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      ST_RD_WAIT: begin
        out_read_value_nxt = rdata_r;
        done               = 1'b1;
        state_nxt          = ST_IDLE;
      end

      ST_SHIFT_DN: begin
        // entry ptr moves to ptr-1 while ptr+1 is fetched
        mem_we    = 1'b1;
        mem_waddr = ptr_dec[IDX_W-1:0];
        mem_wdata = rdata_r;
        if (ptr_inc < cnt_r) begin
          mem_raddr = ptr_inc[IDX_W-1:0];
          ptr_nxt   = ptr_inc;
        end else begin
          cnt_nxt   = cnt_dec;
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_SHIFT_UP: begin
        // entry ptr moves to ptr+1 while ptr-1 is fetched
        mem_we    = 1'b1;
        mem_waddr = ptr_inc[IDX_W-1:0];
        mem_wdata = rdata_r;
        if (ptr_r > pos_r) begin
          mem_raddr = ptr_dec[IDX_W-1:0];
          ptr_nxt   = ptr_dec;
        end else begin
          state_nxt = ST_INS_WR;
        end
      end

      ST_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[IDX_W-1:0];
        mem_wdata = val_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        done      = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt     = done;
    out_status_nxt    = stat;
    out_count_nxt     = cnt_nxt;
    out_empty_res_nxt = (cnt_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r            <= ptr_nxt;
    pos_r            <= pos_nxt;
    val_r            <= val_nxt;
    out_status_r     <= out_status_nxt;
    out_read_value_r <= out_read_value_nxt;
    out_count_r      <= out_count_nxt;
    out_empty_res_r  <= out_empty_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[mem_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = signed'(out_read_value_r);
  assign out_count      = out_count_r;
  assign out_empty_res  = out_empty_res_r;

endmodule
